/* design/tlr_pkg.sv */
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared constants and types of the terminal line edit receiver.
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int unsigned RingDepthDef = 256;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    BEAT_FIRST  = 2'd0,
    BEAT_SECOND = 2'd1,
    BEAT_THIRD  = 2'd2
  } beat_e;

  // one accepted input byte worth of echo work
  typedef struct packed {
    logic        erase;
    logic [7:0]  echo_char;
    logic        done;
    logic [15:0] len;
    logic [7:0]  tail;
  } echo_desc_t;

endpackage

/* design/tlr_ring_mem.sv */
// ----------------------------------------------------------------------------
// tlr_ring_mem
// Receive ring storage, one byte written per cycle at the tail.
// ----------------------------------------------------------------------------
module tlr_ring_mem #(
  parameter int unsigned RING_DEPTH = tlr_pkg::RingDepthDef,
  parameter int unsigned AW         = $clog2(RING_DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i
);
  import tlr_pkg::*;

  logic [7:0] mem [RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

endmodule

/* design/tlr_edit_core.sv */
// ----------------------------------------------------------------------------
// tlr_edit_core
// Line edit state: tail and line count update, ring write, echo descriptor.
// ----------------------------------------------------------------------------
module tlr_edit_core #(
  parameter int unsigned RING_DEPTH = tlr_pkg::RingDepthDef,
  parameter int unsigned AW         = $clog2(RING_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          rx_byte_i,
  output logic                push_o,
  output tlr_pkg::echo_desc_t desc_o,
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output logic [7:0]          wr_data_o
);
  import tlr_pkg::*;

  localparam int unsigned EW = AW + 8;
  localparam logic [AW-1:0] TailLast = AW'(RING_DEPTH - 1);

  logic [AW-1:0] tail_q, tail_d;
  logic [15:0]   count_q, count_d;
  logic [7:0]    ch;
  logic          is_del, is_lf;
  logic [15:0]   count_inc;
  logic [EW-1:0] tail_ext;

  assign ch        = (rx_byte_i == CH_CR) ? CH_LF : rx_byte_i;
  assign is_del    = (ch == CH_DEL);
  assign is_lf     = (ch == CH_LF);
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;

  always_comb begin
    tail_d  = tail_q;
    count_d = count_q;
    push_o  = 1'b0;
    wr_en_o = 1'b0;
    if (take_i) begin
      if (is_del) begin
        if (count_q != 16'd0) begin
          tail_d  = (tail_q == '0) ? TailLast : tail_q - AW'(1);
          count_d = count_q - 16'd1;
          push_o  = 1'b1;
        end
      end else begin
        wr_en_o = 1'b1;
        tail_d  = (tail_q == TailLast) ? '0 : tail_q + AW'(1);
        count_d = is_lf ? 16'd0 : count_inc;
        push_o  = 1'b1;
      end
    end
  end

  assign tail_ext  = EW'(tail_d);
  assign wr_addr_o = tail_q;
  assign wr_data_o = ch;

  assign desc_o.erase     = is_del;
  assign desc_o.echo_char = ch;
  assign desc_o.done      = is_lf;
  assign desc_o.len       = is_lf ? count_inc : 16'd0;
  assign desc_o.tail      = tail_ext[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

/* design/tlr_echo_seq.sv */
// ----------------------------------------------------------------------------
// tlr_echo_seq
// Two-entry descriptor queue and the echo word sequencer on the output side.
// ----------------------------------------------------------------------------
module tlr_echo_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tlr_pkg::echo_desc_t desc_i,
  output logic                room_o,
  output logic                echo_valid_o,
  input  logic                echo_ready_i,
  output logic [7:0]          echo_byte_o,
  output logic                echo_last_o,
  output logic                line_done_o,
  output logic [15:0]         line_length_o,
  output logic [7:0]          tail_index_o
);
  import tlr_pkg::*;

  echo_desc_t  entry_q [QueueDepth];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  beat_e       beat_q, beat_d;
  echo_desc_t  head;
  logic        fire, pop;

  assign head         = entry_q[rd_ptr_q];
  assign echo_valid_o = (fill_q != 2'd0);
  assign room_o       = (fill_q != 2'(QueueDepth));
  assign fire         = echo_valid_o && echo_ready_i;
  assign pop          = fire && (!head.erase || beat_q == BEAT_THIRD);

  always_comb begin
    beat_d = beat_q;
    if (fire) begin
      if (pop) begin
        beat_d = BEAT_FIRST;
      end else begin
        case (beat_q)
          BEAT_FIRST:  beat_d = BEAT_SECOND;
          BEAT_SECOND: beat_d = BEAT_THIRD;
          default:     beat_d = BEAT_FIRST;
        endcase
      end
    end
  end

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push_i) - 2'(pop);
  end

  always_comb begin
    echo_byte_o   = head.echo_char;
    echo_last_o   = 1'b1;
    line_done_o   = head.done;
    line_length_o = head.len;
    tail_index_o  = head.tail;
    if (head.erase) begin
      line_done_o   = 1'b0;
      line_length_o = 16'd0;
      case (beat_q)
        BEAT_FIRST: begin
          echo_byte_o = CH_BS;
          echo_last_o = 1'b0;
        end
        BEAT_SECOND: begin
          echo_byte_o = CH_SP;
          echo_last_o = 1'b0;
        end
        default: begin
          echo_byte_o = CH_BS;
          echo_last_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
      beat_q   <= BEAT_FIRST;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      beat_q   <= beat_d;
    end
  end

endmodule

/* design/tty_line_edit_receiver_unit.sv */
// An accepted byte's echo descriptor is registered into the queue before its first
// echo word is shown. Input takes one byte per cycle while the queue has room; a
// delete on a non-empty line echoes three words through the single output port.
// A two-entry descriptor queue lets input continue while echo words wait.
// Reset clears tail, line count and queue; the ring holds garbage until written.
// ----------------------------------------------------------------------------
// tty_line_edit_receiver_unit
// Canonical line editing of received terminal bytes with echo generation.
// ----------------------------------------------------------------------------
module tty_line_edit_receiver_unit #(
  parameter int unsigned RING_DEPTH = tlr_pkg::RingDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        echo_valid_o,
  input  logic        echo_ready_i,
  output logic [7:0]  echo_byte_o,
  output logic        echo_last_o,
  output logic        line_done_o,
  output logic [15:0] line_length_o,
  output logic [7:0]  tail_index_o
);
  import tlr_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);

  logic          take;
  logic          push;
  echo_desc_t    desc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign take = rx_valid_i && rx_ready_o;

  tlr_edit_core #(
    .RING_DEPTH(RING_DEPTH),
    .AW        (AW)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .rx_byte_i(rx_byte_i),
    .push_o   (push),
    .desc_o   (desc),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data)
  );

  tlr_ring_mem #(
    .RING_DEPTH(RING_DEPTH),
    .AW        (AW)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  tlr_echo_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (desc),
    .room_o       (rx_ready_o),
    .echo_valid_o (echo_valid_o),
    .echo_ready_i (echo_ready_i),
    .echo_byte_o  (echo_byte_o),
    .echo_last_o  (echo_last_o),
    .line_done_o  (line_done_o),
    .line_length_o(line_length_o),
    .tail_index_o (tail_index_o)
  );

`ifndef SYNTHESIS
  a_done_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    echo_valid_o && line_done_o |-> echo_byte_o == CH_LF && echo_last_o)
    else $error("line completion without final line feed word");

  a_len_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    echo_valid_o && line_length_o != 16'd0 |-> line_done_o)
    else $error("line length reported outside line completion");

  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> echo_valid_o)
    else $error("input stalled with no echo word pending");
`endif

endmodule

/* tb/sv/tty_line_edit_receiver_unit_tb.sv */
// ----------------------------------------------------------------------------
// tty_line_edit_receiver_unit_tb
// Drives received terminal bytes into the line edit receiver and checks every
// echo word against a line-editing predictor with its own tail and line count.
// Covers erase on empty and non-empty lines, carriage return mapping,
// back-to-back bytes at full rate and random edited lines,
// with bursty input and a stalling echo sink.
// ----------------------------------------------------------------------------
module tty_line_edit_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlr_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandomBytes = 80;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        echo_last;
    logic        line_done;
    logic [15:0] line_length;
    logic [7:0]  tail_index;
  } echo_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        rx_valid_i;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i;
  logic        echo_valid_o;
  logic        echo_ready_i = 1'b0;
  logic [7:0]  echo_byte_o;
  logic        echo_last_o;
  logic        line_done_o;
  logic [15:0] line_length_o;
  logic [7:0]  tail_index_o;

  echo_word_t  echo_words_q[$];
  echo_word_t  echo_head;
  logic [7:0]  tail_pos;
  logic [15:0] line_cnt;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left;
  int unsigned stretch_left = 0;
  bit          stall_stretch = 1'b0;
  bit          full_rate;

  tty_line_edit_receiver_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .echo_valid_o (echo_valid_o),
    .echo_ready_i (echo_ready_i),
    .echo_byte_o  (echo_byte_o),
    .echo_last_o  (echo_last_o),
    .line_done_o  (line_done_o),
    .line_length_o(line_length_o),
    .tail_index_o (tail_index_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic void predict_line_edit(input logic [7:0] rx);
    logic [7:0] ch;
    ch = (rx == CH_CR) ? CH_LF : rx;
    if (ch == CH_DEL) begin
      if (line_cnt != 16'd0) begin
        tail_pos = tail_pos - 8'd1;
        line_cnt = line_cnt - 16'd1;
        echo_words_q.push_back(echo_word_t'{CH_BS, 1'b0, 1'b0, 16'd0, tail_pos});
        echo_words_q.push_back(echo_word_t'{CH_SP, 1'b0, 1'b0, 16'd0, tail_pos});
        echo_words_q.push_back(echo_word_t'{CH_BS, 1'b1, 1'b0, 16'd0, tail_pos});
      end
    end else begin
      tail_pos = tail_pos + 8'd1;
      if (line_cnt != COUNT_MAX) line_cnt = line_cnt + 16'd1;
      if (ch == CH_LF) begin
        echo_words_q.push_back(echo_word_t'{ch, 1'b1, 1'b1, line_cnt, tail_pos});
        line_cnt = 16'd0;
      end else begin
        echo_words_q.push_back(echo_word_t'{ch, 1'b1, 1'b0, 16'd0, tail_pos});
      end
    end
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || b == CH_DEL) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_rx_byte(input logic [7:0] b);
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    predict_line_edit(b);
    if (!full_rate) begin
      if (burst_left == 0) begin
        rx_valid_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        burst_left = $urandom_range(0, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  // receiver: long ready stretches mixed with stretches of heavy stall
  always @(posedge clk_i) begin
    if (!rst_ni || full_rate) begin
      echo_ready_i <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left  <= $urandom_range(4, 40);
        stall_stretch <= ($urandom_range(0, 2) != 0);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      echo_ready_i <= stall_stretch ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && echo_valid_o && echo_ready_i) begin
      if (echo_words_q.size() == 0) begin
        $error("unexpected echo word: echo_byte %h", echo_byte_o);
        mismatch_cnt++;
      end else begin
        echo_head = echo_words_q.pop_front();
        if (echo_byte_o !== echo_head.echo_byte) begin
          $error("echo_byte: expected %h, got %h", echo_head.echo_byte, echo_byte_o);
          mismatch_cnt++;
        end
        if (echo_last_o !== echo_head.echo_last) begin
          $error("echo_last: expected %b, got %b", echo_head.echo_last, echo_last_o);
          mismatch_cnt++;
        end
        if (line_done_o !== echo_head.line_done) begin
          $error("line_done: expected %b, got %b", echo_head.line_done, line_done_o);
          mismatch_cnt++;
        end
        if (line_length_o !== echo_head.line_length) begin
          $error("line_length: expected %0d, got %0d", echo_head.line_length,
                 line_length_o);
          mismatch_cnt++;
        end
        if (tail_index_o !== echo_head.tail_index) begin
          $error("tail_index: expected %0d, got %0d", echo_head.tail_index,
                 tail_index_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tty_line_edit_receiver_unit_tb failed");
      $finish;
    end
  end

  task automatic test_empty_line_delete();
    send_rx_byte(CH_DEL);
    send_rx_byte(CH_CR);
    send_rx_byte(CH_LF);
    send_rx_byte(CH_DEL);
  endtask

  task automatic test_byte_extremes_and_erase();
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(8'h55);
    send_rx_byte(8'hAA);
    send_rx_byte(CH_BS);
    send_rx_byte(CH_SP);
    repeat (7) send_rx_byte(CH_DEL);
    send_rx_byte(8'h41);
    send_rx_byte(CH_CR);
  endtask

  task automatic test_full_rate_burst();
    full_rate = 1'b1;
    repeat (12) send_rx_byte(plain_byte());
    send_rx_byte(CH_DEL);
    send_rx_byte(CH_DEL);
    send_rx_byte(plain_byte());
    full_rate = 1'b0;
    send_rx_byte(CH_CR);
  endtask

  task automatic test_random_lines();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RandomBytes) begin
      case ($urandom_range(0, 9))
        0: begin
          send_rx_byte(8'($urandom_range(0, 255)));
          sent++;
        end
        1: begin
          repeat ($urandom_range(1, 3)) begin
            send_rx_byte(CH_DEL);
            sent++;
          end
        end
        default: begin
          len = $urandom_range(0, 12);
          repeat (len) begin
            if ($urandom_range(0, 6) == 0) send_rx_byte(CH_DEL);
            else send_rx_byte(8'($urandom_range(8'h20, 8'h7E)));
            sent++;
          end
          send_rx_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    rx_valid_i    = 1'b0;
    rx_byte_i     = 8'h00;
    tail_pos      = 8'd0;
    line_cnt      = 16'd0;
    mismatch_cnt  = 0;
    burst_left    = 0;
    full_rate     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_line_delete();
    test_byte_extremes_and_erase();
    test_full_rate_burst();
    test_random_lines();

    rx_valid_i <= 1'b0;
    while (echo_words_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tty_line_edit_receiver_unit_tb passed");
    end else begin
      $display("tty_line_edit_receiver_unit_tb failed");
    end
    $finish;
  end

endmodule
